// ===== rtl/core/i2cm_pkg.sv =====
// types and constants shared by the i2c master transaction engine
package i2cm_pkg;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_SEND  = 8'b0000_0100,
        ST_ACK   = 8'b0000_1000,
        ST_LOAD  = 8'b0001_0000,
        ST_READ  = 8'b0010_0000,
        ST_MACK  = 8'b0100_0000,
        ST_STOP  = 8'b1000_0000
    } bus_state_t;

    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd4;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    typedef struct packed {
        bus_state_t bus_state;
        logic [1:0] phase_step;
        logic [7:0] phase_timer;
        logic [3:0] bit_counter;
        logic [7:0] bytes_left;
        logic [7:0] shift_reg;
        logic [7:0] timeout_counter;
        logic       direction;
        logic       error_flag;
        logic       scl;
        logic       sda;
    } eng_state_t;

    typedef struct packed {
        logic       start_req;
        logic       read_not_write;
        logic [7:0] slave_addr;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       write_valid;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       write_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic       ack_error;
    } result_t;

endpackage

// ===== rtl/core/i2c_master_transaction_engine.sv =====
// i2c master transaction engine top level: state, config and result registers
//
//  channel   handshake               payload
//  in        in_valid / in_stall     start_req .. sda_in, one word per bus tick
//  out       out_valid / out_stall   scl_out .. ack_error, one word per input word
//  cfg       cfg_we                  cfg_index, cfg_data
//
// one word in, one word out; a new word is taken every cycle unless the output stalls
// the engine state and the result word are both registered at the edge that takes
// the input word, so the result shows on the outputs in the cycle after it is taken
// in_stall is high only while the output register is full and stalled
// reset sets the scl and sda state high and leaves the engine idle; the result word is not reset

module i2c_master_transaction_engine
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_req,
    input  logic       read_not_write,
    input  logic [7:0] slave_addr,
    input  logic [7:0] byte_count,
    input  logic [7:0] write_byte,
    input  logic       write_valid,
    input  logic       sda_in,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic       write_taken,
    output logic [7:0] read_byte,
    output logic       read_valid,
    output logic       done_res,
    output logic       ack_error,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    eng_state_t state_reg;
    eng_state_t state_next;
    result_t    res_reg;
    result_t    res_next;
    logic       out_valid_reg;
    logic [7:0] phase_ticks_reg;
    logic [7:0] ack_timeout_reg;
    tick_t      tick;
    logic       accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign tick.start_req      = start_req;
    assign tick.read_not_write = read_not_write;
    assign tick.slave_addr     = slave_addr;
    assign tick.byte_count     = byte_count;
    assign tick.write_byte     = write_byte;
    assign tick.write_valid    = write_valid;
    assign tick.sda_in         = sda_in;

    i2cm_step u_step
    (
        .cur         (state_reg),
        .tick        (tick),
        .phase_ticks (phase_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.bus_state       <= ST_IDLE;
            state_reg.phase_step      <= 2'd0;
            state_reg.phase_timer     <= 8'd0;
            state_reg.bit_counter     <= 4'd0;
            state_reg.bytes_left      <= 8'd0;
            state_reg.shift_reg       <= 8'd0;
            state_reg.timeout_counter <= 8'd0;
            state_reg.direction       <= 1'b0;
            state_reg.error_flag      <= 1'b0;
            state_reg.scl             <= 1'b1;
            state_reg.sda             <= 1'b1;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result word payload, loaded with each accepted tick
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign scl_out     = res_reg.scl_out;
    assign sda_out     = res_reg.sda_out;
    assign busy_res    = res_reg.busy_res;
    assign write_taken = res_reg.write_taken;
    assign read_byte   = res_reg.read_byte;
    assign read_valid  = res_reg.read_valid;
    assign done_res    = res_reg.done_res;
    assign ack_error   = res_reg.ack_error;

endmodule

// ===== rtl/core/i2cm_step.sv =====
// next-state and result logic for one bus tick
module i2cm_step
    import i2cm_pkg::*;
(
    input  eng_state_t cur,
    input  tick_t      tick,
    input  logic [7:0] phase_ticks,
    input  logic [7:0] ack_timeout,
    output eng_state_t nxt,
    output result_t    res
);

    always_comb
    begin
        logic [7:0] pt;
        logic       phase_end;
        logic       taken;
        logic       rvalid;
        logic [7:0] rbyte;
        logic       done;
        logic       err;

        nxt       = cur;
        pt        = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
        phase_end = 1'b0;
        taken     = 1'b0;
        rvalid    = 1'b0;
        rbyte     = 8'd0;
        done      = 1'b0;
        err       = 1'b0;

        if (cur.bus_state == ST_IDLE)
        begin
            nxt.scl = 1'b1;
            nxt.sda = 1'b1;
            if (tick.start_req)
            begin
                nxt.direction       = tick.read_not_write;
                nxt.shift_reg       = tick.read_not_write ? tick.slave_addr + 8'd1
                                                          : tick.slave_addr;
                nxt.bytes_left      = tick.byte_count;
                nxt.bit_counter     = 4'd0;
                nxt.error_flag      = 1'b0;
                nxt.timeout_counter = 8'd0;
                nxt.bus_state       = ST_START;
                nxt.phase_step      = 2'd0;
                nxt.phase_timer     = 8'd0;
            end
        end
        else if (cur.bus_state == ST_LOAD)
        begin
            if (tick.write_valid)
            begin
                nxt.shift_reg   = tick.write_byte;
                taken           = 1'b1;
                nxt.bytes_left  = cur.bytes_left - 8'd1;
                nxt.bit_counter = 4'd0;
                nxt.bus_state   = ST_SEND;
                nxt.phase_step  = 2'd0;
                nxt.phase_timer = 8'd0;
            end
        end
        else if (cur.bus_state == ST_ACK && cur.phase_step == 2'd2)
        begin
            // sample the slave ack once per tick while scl is high
            if (!tick.sda_in)
            begin
                nxt.phase_step  = 2'd3;
                nxt.phase_timer = 8'd0;
            end
            else if (cur.timeout_counter >= ack_timeout)
            begin
                nxt.error_flag  = 1'b1;
                nxt.bus_state   = ST_STOP;
                nxt.phase_step  = 2'd0;
                nxt.phase_timer = 8'd0;
            end
            else
            begin
                nxt.timeout_counter = cur.timeout_counter + 8'd1;
            end
        end
        else if (cur.bus_state inside {ST_START, ST_SEND, ST_ACK, ST_READ, ST_MACK, ST_STOP})
        begin
            // line action on the first tick of a phase
            if (cur.phase_timer == 8'd0)
            begin
                case (cur.bus_state)
                    ST_START:
                    begin
                        if (cur.phase_step == 2'd0)
                        begin
                            nxt.sda = 1'b1;
                            nxt.scl = 1'b1;
                        end
                        else if (cur.phase_step == 2'd1)
                            nxt.sda = 1'b0;
                        else
                            nxt.scl = 1'b0;
                    end
                    ST_SEND:
                    begin
                        if (cur.phase_step == 2'd0)
                            nxt.sda = cur.shift_reg[7];
                        else if (cur.phase_step == 2'd1)
                            nxt.scl = 1'b1;
                        else
                            nxt.scl = 1'b0;
                    end
                    ST_ACK:
                    begin
                        if (cur.phase_step == 2'd0)
                            nxt.sda = 1'b1;
                        else if (cur.phase_step == 2'd1)
                            nxt.scl = 1'b1;
                        else if (cur.phase_step == 2'd3)
                            nxt.scl = 1'b0;
                    end
                    ST_READ:
                    begin
                        if (cur.phase_step == 2'd0)
                        begin
                            nxt.sda = 1'b1;
                            nxt.scl = 1'b1;
                        end
                        else if (cur.phase_step == 2'd2)
                            nxt.scl = 1'b0;
                    end
                    ST_MACK:
                    begin
                        if (cur.phase_step == 2'd0)
                            nxt.sda = (cur.bytes_left == 8'd0);
                        else if (cur.phase_step == 2'd1)
                            nxt.scl = 1'b1;
                        else
                            nxt.scl = 1'b0;
                    end
                    ST_STOP:
                    begin
                        // scl goes low with sda so no false start appears
                        if (cur.phase_step == 2'd0)
                        begin
                            nxt.scl = 1'b0;
                            nxt.sda = 1'b0;
                        end
                        else if (cur.phase_step == 2'd1)
                            nxt.scl = 1'b1;
                        else
                            nxt.sda = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            nxt.phase_timer = cur.phase_timer + 8'd1;
            if (nxt.phase_timer >= pt)
            begin
                nxt.phase_timer = 8'd0;
                phase_end       = 1'b1;
            end
        end
        else
        begin
            nxt.bus_state   = ST_IDLE;
            nxt.phase_step  = 2'd0;
            nxt.phase_timer = 8'd0;
        end

        if (phase_end)
        begin
            case (cur.bus_state)
                ST_START:
                begin
                    if (cur.phase_step < 2'd2)
                        nxt.phase_step = cur.phase_step + 2'd1;
                    else
                    begin
                        nxt.bit_counter = 4'd0;
                        nxt.bus_state   = ST_SEND;
                        nxt.phase_step  = 2'd0;
                        nxt.phase_timer = 8'd0;
                    end
                end
                ST_SEND:
                begin
                    if (cur.phase_step < 2'd2)
                        nxt.phase_step = cur.phase_step + 2'd1;
                    else
                    begin
                        nxt.shift_reg   = {cur.shift_reg[6:0], 1'b0};
                        nxt.bit_counter = cur.bit_counter + 4'd1;
                        if (nxt.bit_counter >= 4'd8)
                        begin
                            nxt.timeout_counter = 8'd0;
                            nxt.bus_state       = ST_ACK;
                            nxt.phase_step      = 2'd0;
                            nxt.phase_timer     = 8'd0;
                        end
                        else
                            nxt.phase_step = 2'd0;
                    end
                end
                ST_ACK:
                begin
                    if (cur.phase_step < 2'd2)
                        nxt.phase_step = cur.phase_step + 2'd1;
                    else
                    begin
                        nxt.phase_step  = 2'd0;
                        nxt.phase_timer = 8'd0;
                        if (cur.bytes_left == 8'd0)
                            nxt.bus_state = ST_STOP;
                        else if (cur.direction)
                        begin
                            nxt.bit_counter = 4'd0;
                            nxt.shift_reg   = 8'd0;
                            nxt.bus_state   = ST_READ;
                        end
                        else
                            nxt.bus_state = ST_LOAD;
                    end
                end
                ST_READ:
                begin
                    if (cur.phase_step == 2'd0)
                        nxt.shift_reg = {cur.shift_reg[6:0], tick.sda_in};
                    if (cur.phase_step < 2'd2)
                        nxt.phase_step = cur.phase_step + 2'd1;
                    else
                    begin
                        nxt.bit_counter = cur.bit_counter + 4'd1;
                        if (nxt.bit_counter >= 4'd8)
                        begin
                            rvalid          = 1'b1;
                            rbyte           = cur.shift_reg;
                            nxt.bytes_left  = cur.bytes_left - 8'd1;
                            nxt.bus_state   = ST_MACK;
                            nxt.phase_step  = 2'd0;
                            nxt.phase_timer = 8'd0;
                        end
                        else
                            nxt.phase_step = 2'd0;
                    end
                end
                ST_MACK:
                begin
                    if (cur.phase_step < 2'd2)
                        nxt.phase_step = cur.phase_step + 2'd1;
                    else
                    begin
                        nxt.sda         = 1'b1;
                        nxt.phase_step  = 2'd0;
                        nxt.phase_timer = 8'd0;
                        if (cur.bytes_left == 8'd0)
                            nxt.bus_state = ST_STOP;
                        else
                        begin
                            nxt.bit_counter = 4'd0;
                            nxt.shift_reg   = 8'd0;
                            nxt.bus_state   = ST_READ;
                        end
                    end
                end
                ST_STOP:
                begin
                    if (cur.phase_step < 2'd2)
                        nxt.phase_step = cur.phase_step + 2'd1;
                    else
                    begin
                        done            = 1'b1;
                        err             = cur.error_flag;
                        nxt.bus_state   = ST_IDLE;
                        nxt.phase_step  = 2'd0;
                        nxt.phase_timer = 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.scl_out     = nxt.scl;
        res.sda_out     = nxt.sda;
        res.busy_res    = (nxt.bus_state != ST_IDLE);
        res.write_taken = taken;
        res.read_byte   = rbyte;
        res.read_valid  = rvalid;
        res.done_res    = done;
        res.ack_error   = err;
    end

endmodule
